// File: src/ggr_pkg.sv
// Package for the Givens rotation generator: fixed-point constants and the
// sideband struct that travels with every word. No dependencies.
`default_nettype none
package ggr_pkg;

    localparam int FRAC_BITS = 22;
    // Bits of the doubled ratio: the largest value is 2^(FRAC_BITS+1).
    localparam int K_W = FRAC_BITS + 2;
    localparam int OUT_W = 24;
    localparam logic [OUT_W-1:0] ONE_FX = OUT_W'(1) << FRAC_BITS;
    localparam logic [OUT_W-1:0] MAG_MAX = '1;

    typedef struct packed {
        logic valid;
        logic neg_a;
        logic neg_b;
        logic zero;
    } t_ctl;

endpackage
`default_nettype wire

// File: src/ggr_if.sv
// Channel interfaces of the Givens rotation generator: input pair and result.
// Depends on ggr_pkg.
`default_nettype none
interface ggr_in_if #(parameter int IN_WIDTH = 24);
    logic                       valid;
    logic                       ready;
    logic signed [IN_WIDTH-1:0] a_in;
    logic signed [IN_WIDTH-1:0] b_in;
    modport source (output valid, output a_in, output b_in, input ready);
    modport sink (input valid, input a_in, input b_in, output ready);
endinterface

interface ggr_out_if;
    import ggr_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] cos_val;
    logic signed [OUT_W-1:0] sin_val;
    logic        [OUT_W-1:0] magnitude;
    modport source (output valid, output cos_val, output sin_val, output magnitude,
                    input ready);
    modport sink (input valid, input cos_val, input sin_val, input magnitude,
                  output ready);
endinterface
`default_nettype wire

// File: src/givens_rotation_generator_unit.sv
// Top level of the Givens rotation generator: front stages, cell chain, output
// register. Depends on ggr_pkg, ggr_if and ggr_cell.
//
// Usage: a pair (a_in, b_in) enters on the i_in channel, a word of cos_val,
// sin_val and magnitude leaves on o_out. Both use valid/ready; a word moves on
// a clock edge with valid and ready high. One pair is taken every cycle unless
// the output stalls. The path has two front stages (absolute values, then the
// squares and their sum), one cell per bit of the longer of the square root
// (IN_WIDTH bits) and the ratio search (24 bits), and the output register
// where rounding and signs are applied. Throughput is one word per cycle
// while the output is not stalled; the chain holds one pair in each cell.
// When the receiver stalls with a word waiting, the whole chain holds and
// i_in.ready drops; it rises again as soon as the output word is taken.
// Synchronous reset clears all valid flags; data registers are not reset.
// A zero pair gives cos 0, sin 1.0 and magnitude 0.
`default_nettype none
module givens_rotation_generator_unit import ggr_pkg::*; #(
    parameter int IN_WIDTH = 24
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    ggr_in_if.sink    i_in,
    ggr_out_if.source o_out
);

    localparam int W   = IN_WIDTH;
    localparam int SW  = 2 * W;
    localparam int RMW = W + 3;
    localparam int TW  = 2 * W + 49;
    localparam int NST = (W > K_W) ? W : K_W;

    logic adv;

    // front stage one: absolute values
    t_ctl          r_c1;
    logic [W-1:0]  r_am, r_bm;
    logic [W-1:0]  abs_a, abs_b;
    // front stage two: squares and their sum
    t_ctl          r_c2;
    logic [SW-1:0] r_a2, r_b2, r_sum;

    t_ctl             s_ctl  [0:NST];
    logic [SW-1:0]    s_sum  [0:NST];
    logic [RMW-1:0]   s_rem  [0:NST];
    logic [W-1:0]     s_root [0:NST];
    logic [TW-1:0]    s_ra   [0:NST];
    logic [TW-1:0]    s_pa   [0:NST];
    logic [K_W-1:0]   s_ka   [0:NST];
    logic [TW-1:0]    s_rb   [0:NST];
    logic [TW-1:0]    s_pb   [0:NST];
    logic [K_W-1:0]   s_kb   [0:NST];

    logic                    r_ovalid;
    logic signed [OUT_W-1:0] r_cos, r_sin;
    logic        [OUT_W-1:0] r_mag;
    logic        [OUT_W-1:0] n_cos, n_sin, n_mag;

    assign adv        = !r_ovalid || o_out.ready;
    assign i_in.ready = adv;

    assign abs_a = i_in.a_in[W-1] ? (~i_in.a_in + W'(1)) : i_in.a_in;
    assign abs_b = i_in.b_in[W-1] ? (~i_in.b_in + W'(1)) : i_in.b_in;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1     <= '0;
            r_c2     <= '0;
            r_ovalid <= 1'b0;
        end else if (adv) begin
            r_c1.valid <= i_in.valid;
            r_c1.neg_a <= i_in.a_in[W-1];
            r_c1.neg_b <= i_in.b_in[W-1];
            r_c1.zero  <= (i_in.a_in == '0) && (i_in.b_in == '0);
            r_c2       <= r_c1;
            r_ovalid   <= s_ctl[NST].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_am  <= abs_a;
            r_bm  <= abs_b;
            r_a2  <= SW'(r_am) * SW'(r_am);
            r_b2  <= SW'(r_bm) * SW'(r_bm);
            r_sum <= SW'(r_am) * SW'(r_am) + SW'(r_bm) * SW'(r_bm);
            r_cos <= n_cos;
            r_sin <= n_sin;
            r_mag <= n_mag;
        end
    end

    // seed the chain: remainders start at m^2 * 2^(2*FRAC_BITS+2)
    assign s_ctl[0]  = r_c2;
    assign s_sum[0]  = r_sum;
    assign s_rem[0]  = '0;
    assign s_root[0] = '0;
    assign s_ra[0]   = TW'(r_a2) << (2 * FRAC_BITS + 2);
    assign s_pa[0]   = '0;
    assign s_ka[0]   = '0;
    assign s_rb[0]   = TW'(r_b2) << (2 * FRAC_BITS + 2);
    assign s_pb[0]   = '0;
    assign s_kb[0]   = '0;

    generate
        for (genvar g = 0; g < NST; g++) begin : g_cells
            ggr_cell #(.W(W), .STAGE(g)) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_adv   (adv),
                .i_ctl   (s_ctl[g]),
                .i_sum   (s_sum[g]),
                .i_rem   (s_rem[g]),
                .i_root  (s_root[g]),
                .i_ra    (s_ra[g]),
                .i_pa    (s_pa[g]),
                .i_ka    (s_ka[g]),
                .i_rb    (s_rb[g]),
                .i_pb    (s_pb[g]),
                .i_kb    (s_kb[g]),
                .o_ctl   (s_ctl[g+1]),
                .o_sum   (s_sum[g+1]),
                .o_rem   (s_rem[g+1]),
                .o_root  (s_root[g+1]),
                .o_ra    (s_ra[g+1]),
                .o_pa    (s_pa[g+1]),
                .o_ka    (s_ka[g+1]),
                .o_rb    (s_rb[g+1]),
                .o_pb    (s_pb[g+1]),
                .o_kb    (s_kb[g+1])
            );
        end
    endgenerate

    // round the root to nearest: step up when the remainder exceeds the root
    logic [W:0]       mag_full;
    logic [OUT_W-1:0] mag_sat;
    logic [K_W:0]     ka_p1, kb_p1;
    logic [OUT_W-1:0] na, nb;

    assign mag_full = {1'b0, s_root[NST]} +
                      (W+1)'(s_rem[NST] > RMW'(s_root[NST]));

    generate
        if (W + 1 > OUT_W) begin : g_sat
            assign mag_sat = (|mag_full[W:OUT_W]) ? MAG_MAX : mag_full[OUT_W-1:0];
        end else begin : g_nosat
            assign mag_sat = OUT_W'(mag_full);
        end
    endgenerate

    // the largest k with k^2 * sum within the bound gives n = (k + 1) / 2
    assign ka_p1 = {1'b0, s_ka[NST]} + (K_W+1)'(1);
    assign kb_p1 = {1'b0, s_kb[NST]} + (K_W+1)'(1);
    assign na    = OUT_W'(ka_p1[K_W:1]);
    assign nb    = OUT_W'(kb_p1[K_W:1]);

    always_comb begin
        if (s_ctl[NST].zero) begin
            n_cos = '0;
            n_sin = ONE_FX;
            n_mag = '0;
        end else begin
            n_cos = s_ctl[NST].neg_a ? (~na + OUT_W'(1)) : na;
            n_sin = s_ctl[NST].neg_b ? (~nb + OUT_W'(1)) : nb;
            n_mag = mag_sat;
        end
    end

    assign o_out.valid     = r_ovalid;
    assign o_out.cos_val   = r_cos;
    assign o_out.sin_val   = r_sin;
    assign o_out.magnitude = r_mag;

endmodule
`default_nettype wire

// File: src/ggr_cell.sv
// One cell of the rotation chain: at most one bit of the square root and one bit of
// each of the two ratio searches; a cell past the end of a search passes it on. Depends on ggr_pkg.
`default_nettype none
module ggr_cell import ggr_pkg::*; #(
    parameter int W     = 24,
    parameter int STAGE = 0
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_adv,
    input  wire t_ctl              i_ctl,
    input  wire logic [2*W-1:0]    i_sum,
    input  wire logic [W+2:0]      i_rem,
    input  wire logic [W-1:0]      i_root,
    input  wire logic [2*W+48:0]   i_ra,
    input  wire logic [2*W+48:0]   i_pa,
    input  wire logic [K_W-1:0]    i_ka,
    input  wire logic [2*W+48:0]   i_rb,
    input  wire logic [2*W+48:0]   i_pb,
    input  wire logic [K_W-1:0]    i_kb,
    output t_ctl                   o_ctl,
    output logic [2*W-1:0]         o_sum,
    output logic [W+2:0]           o_rem,
    output logic [W-1:0]           o_root,
    output logic [2*W+48:0]        o_ra,
    output logic [2*W+48:0]        o_pa,
    output logic [K_W-1:0]         o_ka,
    output logic [2*W+48:0]        o_rb,
    output logic [2*W+48:0]        o_pb,
    output logic [K_W-1:0]         o_kb
);

    localparam int SW  = 2 * W;
    localparam int RMW = W + 3;
    localparam int TW  = 2 * W + 49;

    t_ctl             r_ctl;
    logic [SW-1:0]    r_sum;
    logic [RMW-1:0]   r_rem, n_rem;
    logic [W-1:0]     r_root, n_root;
    logic [TW-1:0]    r_ra, n_ra, r_pa, n_pa, r_rb, n_rb, r_pb, n_pb;
    logic [K_W-1:0]   r_ka, n_ka, r_kb, n_kb;

    generate
        if (STAGE < W) begin : g_sqrt
            localparam int SQ_J = W - 1 - STAGE;
            logic [RMW-1:0] rem_sh;
            logic [RMW-1:0] trial;
            always_comb begin
                rem_sh = {i_rem[RMW-3:0], i_sum[2*SQ_J+1 -: 2]};
                trial  = {1'b0, i_root, 2'b01};
                if (rem_sh >= trial) begin
                    n_rem  = rem_sh - trial;
                    n_root = {i_root[W-2:0], 1'b1};
                end else begin
                    n_rem  = rem_sh;
                    n_root = {i_root[W-2:0], 1'b0};
                end
            end
        end else begin : g_sqrt_hold
            assign n_rem  = i_rem;
            assign n_root = i_root;
        end

        if (STAGE < K_W) begin : g_ratio
            localparam int RT_J = K_W - 1 - STAGE;
            logic [TW:0]   try_a, try_b;
            logic [TW-1:0] sum_x;
            always_comb begin
                sum_x = TW'(i_sum);
                try_a = ({1'b0, i_pa} << (RT_J + 1)) + ({1'b0, sum_x} << (2 * RT_J));
                try_b = ({1'b0, i_pb} << (RT_J + 1)) + ({1'b0, sum_x} << (2 * RT_J));
                n_ra = i_ra;
                n_pa = i_pa;
                n_ka = i_ka;
                n_rb = i_rb;
                n_pb = i_pb;
                n_kb = i_kb;
                // take the bit when the enlarged square still fits
                if (try_a <= {1'b0, i_ra}) begin
                    n_ra = i_ra - try_a[TW-1:0];
                    n_pa = i_pa + (sum_x << RT_J);
                    n_ka[RT_J] = 1'b1;
                end
                if (try_b <= {1'b0, i_rb}) begin
                    n_rb = i_rb - try_b[TW-1:0];
                    n_pb = i_pb + (sum_x << RT_J);
                    n_kb[RT_J] = 1'b1;
                end
            end
        end else begin : g_ratio_hold
            assign n_ra = i_ra;
            assign n_pa = i_pa;
            assign n_ka = i_ka;
            assign n_rb = i_rb;
            assign n_pb = i_pb;
            assign n_kb = i_kb;
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_adv) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_sum  <= i_sum;
            r_rem  <= n_rem;
            r_root <= n_root;
            r_ra   <= n_ra;
            r_pa   <= n_pa;
            r_ka   <= n_ka;
            r_rb   <= n_rb;
            r_pb   <= n_pb;
            r_kb   <= n_kb;
        end
    end

    assign o_ctl  = r_ctl;
    assign o_sum  = r_sum;
    assign o_rem  = r_rem;
    assign o_root = r_root;
    assign o_ra   = r_ra;
    assign o_pa   = r_pa;
    assign o_ka   = r_ka;
    assign o_rb   = r_rb;
    assign o_pb   = r_pb;
    assign o_kb   = r_kb;

endmodule
`default_nettype wire

// File: src/ggr_checker.sv
// Port-level checks for the Givens rotation generator, bound to the top level.
// Depends on ggr_pkg and givens_rotation_generator_unit.
`default_nettype none
module ggr_checker import ggr_pkg::*; (
    input wire logic                    i_clk,
    input wire logic                    i_rst_n,
    input wire logic                    i_in_ready,
    input wire logic                    i_out_valid,
    input wire logic                    i_out_ready,
    input wire logic signed [OUT_W-1:0] i_cos,
    input wire logic signed [OUT_W-1:0] i_sin,
    input wire logic        [OUT_W-1:0] i_mag
);

    localparam logic signed [OUT_W-1:0] POS_ONE = ONE_FX;
    localparam logic signed [OUT_W-1:0] NEG_ONE = -ONE_FX;

    a_rst_clears: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("output word valid after reset");

    a_no_bubble_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input held off with empty output register");

    a_hold_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_cos) && $stable(i_sin)
        && $stable(i_mag))
        else $error("stalled output word changed");

    a_unit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_cos <= POS_ONE) && (i_cos >= NEG_ONE)
        && (i_sin <= POS_ONE) && (i_sin >= NEG_ONE))
        else $error("cos or sin beyond unity");

    a_zero_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_mag == '0) |-> (i_cos == '0) && (i_sin == POS_ONE))
        else $error("zero magnitude without the zero-pair rotation");

endmodule

bind givens_rotation_generator_unit ggr_checker u_ggr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_cos       (o_out.cos_val),
    .i_sin       (o_out.sin_val),
    .i_mag       (o_out.magnitude)
);
`default_nettype wire
